// File: sv/umep_pkg.sv
// Shared types and constants for the USB-MIDI event packet encoder.
// No dependencies; used by umep_encode and usb_midi_event_packet_encoder_top.
package umep_pkg;

    // Item kinds carried on s_tuser.
    typedef enum logic [1:0] {
        MODE_NOTE_ON  = 2'd0,
        MODE_NOTE_OFF = 2'd1,
        MODE_SYSEX    = 2'd2
    } mode_t;

    // Code index numbers.
    localparam logic [3:0] CIN_NOTE_ON    = 4'h9;
    localparam logic [3:0] CIN_NOTE_OFF   = 4'h8;
    localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
    localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
    localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
    localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;

    // Status bytes and the data byte mask.
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] DATA_MASK       = 8'h7F;

    localparam int unsigned HELD_DEPTH = 3;

    typedef struct packed {
        mode_t       mode;
        logic [3:0]  cable;
        logic [3:0]  channel;
        logic [7:0]  data_byte;
        logic [6:0]  velocity;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [7:0]  header;
        logic [7:0]  midi_byte_one;
        logic [7:0]  midi_byte_two;
        logic [7:0]  midi_byte_three;
        logic        end_of_run;
    } packet_t;

    typedef struct packed {
        logic [HELD_DEPTH-1:0][7:0] held_bytes;
        logic [1:0]                 held_count;
        logic [3:0]                 message_cable;
    } enc_state_t;

    typedef struct packed {
        logic [1:0]  count;     // packets produced: 0, 1 or 2
        packet_t     pkt0;
        packet_t     pkt1;
        enc_state_t  next_state;
    } enc_result_t;

endpackage

// File: sv/usb_midi_event_packet_encoder_top.sv
// USB-MIDI event packet encoder, top level: input register, packet builder,
// output register with a one-packet overflow stage. Depends on umep_pkg and umep_encode.
//
// Usage: each input transaction on the s_ channel carries one MIDI item. s_tuser
// gives its kind (note on, note off, one SysEx byte) and s_tlast marks the final
// byte of a SysEx message. Each output transaction on the m_ channel is one
// 4-byte USB-MIDI event packet; m_tlast is high on the last packet caused by an
// input item. Notes give one packet; SysEx bytes are gathered three at a time,
// and a final byte can give two packets (a continuation packet and an end packet).
//
// An item is taken into the input register, the packet builder works on it there
// and writes the result register, from which the first packet shows on the m_
// side. Items are taken at one item per cycle while the receiver keeps up; an
// item that gives two packets holds the next one while the second packet moves
// from the overflow stage into the result register.
//
// When the receiver stalls, packets wait in the result register and the
// overflow stage; items that give no packet still pass, and the input register
// holds one more item before s_tready drops. Reset (aresetn low, synchronous)
// empties all stages and clears the held SysEx bytes, their count and the
// latched cable.
module usb_midi_event_packet_encoder_top
    import umep_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // cable[3:0], channel[7:4], data_byte[15:8],
                                   // velocity[22:16], zero pad[23]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // header[7:0], midi_byte_one[15:8],
                                   // midi_byte_two[23:16], midi_byte_three[31:24]
    output logic        m_tlast
);

    // Input register.
    logic        in_valid_reg, in_valid_next;
    item_t       in_item_reg;

    // SysEx state.
    enc_state_t  state_reg;

    // Result register and overflow stage.
    logic        out_valid_reg, out_valid_next;
    packet_t     out_pkt_reg, out_pkt_next;
    logic        pend_valid_reg, pend_valid_next;
    packet_t     pend_pkt_reg, pend_pkt_next;

    enc_result_t enc;
    logic        out_free;
    logic        consume;
    item_t       s_item;

    umep_encode u_encode (
        .item   (in_item_reg),
        .state  (state_reg),
        .result (enc)
    );

    assign s_item = '{mode: mode_t'(s_tuser),
                      cable: s_tdata[3:0],
                      channel: s_tdata[7:4],
                      data_byte: s_tdata[15:8],
                      velocity: s_tdata[22:16],
                      last: s_tlast};

    // The result register is free this cycle if empty or being taken.
    assign out_free = !out_valid_reg || m_tready;
    // An item that gives no packet always passes; otherwise both output stages
    // must be free after this cycle.
    assign consume  = in_valid_reg &&
                      ((enc.count == 2'd0) || (out_free && !pend_valid_reg));
    assign s_tready = !in_valid_reg || consume;

    always_comb begin
        in_valid_next   = in_valid_reg;
        out_valid_next  = out_valid_reg;
        out_pkt_next    = out_pkt_reg;
        pend_valid_next = pend_valid_reg;
        pend_pkt_next   = pend_pkt_reg;

        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end

        if (consume && enc.count != 2'd0) begin
            out_valid_next = 1'b1;
            out_pkt_next   = enc.pkt0;
            if (enc.count == 2'd2) begin
                pend_valid_next = 1'b1;
                pend_pkt_next   = enc.pkt1;
            end
        end else if (out_free && pend_valid_reg) begin
            out_valid_next  = 1'b1;
            out_pkt_next    = pend_pkt_reg;
            pend_valid_next = 1'b0;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            state_reg      <= '0;
        end else begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (consume) begin
                state_reg <= enc.next_state;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_item;
        end
        out_pkt_reg  <= out_pkt_next;
        pend_pkt_reg <= pend_pkt_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pkt_reg.midi_byte_three, out_pkt_reg.midi_byte_two,
                       out_pkt_reg.midi_byte_one, out_pkt_reg.header};
    assign m_tlast  = out_pkt_reg.end_of_run;

    // The overflow stage is only ever filled behind a full result register.
    a_pend_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> out_valid_reg)
        else $error("overflow packet without a packet in the result register");

    // An item giving two packets fills both output stages.
    a_two_packets: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && enc.count == 2'd2 |=> pend_valid_reg && out_valid_reg)
        else $error("second packet of an item was lost");

    // A non-final SysEx byte after three held bytes leaves exactly one held.
    a_flush_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && in_item_reg.mode == MODE_SYSEX && !in_item_reg.last &&
        state_reg.held_count == 2'd3 |=> state_reg.held_count == 2'd1)
        else $error("held byte count wrong after a continuation packet");

    // Items that give no packet never touch the output stages.
    a_no_packet_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && enc.count == 2'd0 && !out_valid_reg && !pend_valid_reg
        |=> !out_valid_reg)
        else $error("packet appeared for an item that gives none");

endmodule

// File: sv/umep_encode.sv
// Combinational packet builder: one item plus the held SysEx state in,
// up to two event packets and the next state out. Depends on umep_pkg.
module umep_encode
    import umep_pkg::*;
(
    input  item_t       item,
    input  enc_state_t  state,
    output enc_result_t result
);

    always_comb begin
        logic [3:0] cab;
        logic [1:0] cnt;
        logic       flushed;
        packet_t    end_pkt;

        result            = '0;
        result.next_state = state;
        cab               = state.message_cable;
        cnt               = state.held_count;
        flushed           = 1'b0;
        end_pkt           = '0;

        case (item.mode)
            MODE_NOTE_ON: begin
                result.count = 2'd1;
                result.pkt0  = '{header: {item.cable, CIN_NOTE_ON},
                                 midi_byte_one: STATUS_NOTE_ON | {4'h0, item.channel},
                                 midi_byte_two: item.data_byte & DATA_MASK,
                                 midi_byte_three: {1'b0, item.velocity},
                                 end_of_run: 1'b1};
            end
            MODE_NOTE_OFF: begin
                result.count = 2'd1;
                result.pkt0  = '{header: {item.cable, CIN_NOTE_OFF},
                                 midi_byte_one: STATUS_NOTE_OFF | {4'h0, item.channel},
                                 midi_byte_two: item.data_byte & DATA_MASK,
                                 midi_byte_three: 8'h00,
                                 end_of_run: 1'b1};
            end
            MODE_SYSEX: begin
                // The cable is latched at the first byte of a message.
                if (state.held_count == 2'd0) begin
                    cab = item.cable;
                end
                result.next_state.message_cable = cab;

                // Three bytes already held: they go out as a continuation packet.
                if (state.held_count == 2'd3) begin
                    flushed     = 1'b1;
                    cnt         = 2'd0;
                    result.pkt0 = '{header: {cab, CIN_SYSEX_CONT},
                                    midi_byte_one: state.held_bytes[0],
                                    midi_byte_two: state.held_bytes[1],
                                    midi_byte_three: state.held_bytes[2],
                                    end_of_run: ~item.last};
                end

                if (!item.last) begin
                    case (cnt)
                        2'd0: result.next_state.held_bytes[0] = item.data_byte;
                        2'd1: result.next_state.held_bytes[1] = item.data_byte;
                        default: result.next_state.held_bytes[2] = item.data_byte;
                    endcase
                    result.next_state.held_count = cnt + 2'd1;
                    result.count                 = {1'b0, flushed};
                end else begin
                    case (cnt)
                        2'd0: end_pkt = '{header: {cab, CIN_SYSEX_END1},
                                          midi_byte_one: item.data_byte,
                                          midi_byte_two: 8'h00,
                                          midi_byte_three: 8'h00,
                                          end_of_run: 1'b1};
                        2'd1: end_pkt = '{header: {cab, CIN_SYSEX_END2},
                                          midi_byte_one: state.held_bytes[0],
                                          midi_byte_two: item.data_byte,
                                          midi_byte_three: 8'h00,
                                          end_of_run: 1'b1};
                        default: end_pkt = '{header: {cab, CIN_SYSEX_END3},
                                             midi_byte_one: state.held_bytes[0],
                                             midi_byte_two: state.held_bytes[1],
                                             midi_byte_three: item.data_byte,
                                             end_of_run: 1'b1};
                    endcase
                    if (flushed) begin
                        result.pkt1  = end_pkt;
                        result.count = 2'd2;
                    end else begin
                        result.pkt0  = end_pkt;
                        result.count = 2'd1;
                    end
                    result.next_state.held_count = 2'd0;
                end
            end
            default: begin
                // Unused kind: no packet, state unchanged.
                result.count = 2'd0;
            end
        endcase
    end

endmodule
